// File: rtl/core/mwm_pkg.sv
// ============================================================================
// mwm_pkg - shared types and constants of the mecanum wheel mixer
// Fixed-point widths, mixing signs, clamp limits and pipeline stage numbers.
// ============================================================================
package mwm_pkg;

    localparam int FRACTION_BITS = 14;

    localparam int LANES  = 4;
    localparam int AXES   = 3;
    localparam int CMD_W  = 16;
    localparam int SPD_W  = CMD_W + 2;
    localparam int AMP_W  = CMD_W + 1;
    localparam int MOP_W  = SPD_W + 1;
    localparam int NEU_W  = 11;
    localparam int FS_W   = 9;
    localparam int OFS_W  = 6;
    localparam int PROD_W = FS_W + 1 + MOP_W;
    localparam int NUM_W  = PROD_W;
    localparam int DEN_W  = AMP_W + 1;
    localparam int QUO_W  = FS_W + 2;
    localparam int Q_W    = QUO_W + 1;
    localparam int R_W    = Q_W + 1;
    localparam int OUT_W  = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = NEU_W;

    localparam int CLAMP_HI_INT = (FRACTION_BITS < CMD_W - 1) ?
                                  (1 << FRACTION_BITS) : ((1 << (CMD_W - 1)) - 1);
    localparam int CLAMP_LO_INT = (FRACTION_BITS < CMD_W - 1) ?
                                  -(1 << FRACTION_BITS) : -(1 << (CMD_W - 1));
    localparam logic signed [CMD_W-1:0] CLAMP_HI = CMD_W'(CLAMP_HI_INT);
    localparam logic signed [CMD_W-1:0] CLAMP_LO = CMD_W'(CLAMP_LO_INT);

    localparam int LIMIT_INT = 1 << (FRACTION_BITS + 1);
    localparam int HALF_INT  = 1 << (FRACTION_BITS - 1);
    localparam int OUT_MAX   = (1 << OUT_W) - 1;

    // bit j set: axis j (forward, side, turn) enters the wheel negated
    localparam logic [AXES-1:0] MIX_NEG [LANES] = '{3'b110, 3'b100, 3'b000, 3'b010};

    localparam logic [NEU_W-1:0] NEUTRAL_RST = NEU_W'(1500);
    localparam logic [FS_W-1:0]  FS_RST      = FS_W'(100);
    localparam logic [OFS_W-1:0] OFS_RST     = OFS_W'(2);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NEUTRAL    = 2'd0,
        CFG_FULL_SCALE = 2'd1,
        CFG_REV_OFFSET = 2'd2
    } cfg_idx_t;

    localparam int ST_CLAMP = 0;
    localparam int ST_MIX   = 1;
    localparam int ST_AMP   = 2;
    localparam int ST_MOP   = 3;
    localparam int ST_PROD  = 4;
    localparam int ST_NUM   = 5;
    localparam int ST_DIV0  = 6;
    localparam int ST_OFS   = ST_DIV0 + QUO_W;
    localparam int ST_OUT   = ST_OFS + 1;
    localparam int NSTG     = ST_OUT + 1;
    localparam int CNT_W    = $clog2(NSTG + 1);

    typedef struct packed {
        logic                        scale;
        logic [LANES-1:0][Q_W-1:0]   q_plain;
    } div_side_t;

endpackage

// File: rtl/core/mwm_divider.sv
// ============================================================================
// mwm_divider - pipelined restoring divider, four lanes, one bit per stage
// Shares one denominator across the lanes and carries side data alongside.
// ============================================================================
module mwm_divider import mwm_pkg::*; (
    input  logic                            aclk,
    input  logic [QUO_W-1:0]                en,
    input  logic [LANES-1:0][NUM_W-1:0]     num_in,
    input  logic [DEN_W-1:0]                den_in,
    input  div_side_t                       side_in,
    output logic [LANES-1:0][QUO_W-1:0]     quo_out,
    output div_side_t                       side_out
);

    logic [LANES-1:0][NUM_W-1:0] rem_reg  [QUO_W-1];
    logic [DEN_W-1:0]            den_reg  [QUO_W-1];
    logic [LANES-1:0][QUO_W-1:0] quo_reg  [QUO_W];
    div_side_t                   side_reg [QUO_W];

    for (genvar k = 0; k < QUO_W; k++) begin : g_step
        localparam int B = QUO_W - 1 - k;
        logic [LANES-1:0][NUM_W-1:0] rem_in;
        logic [LANES-1:0][QUO_W-1:0] quo_in;
        logic [DEN_W-1:0]            den_cur;
        div_side_t                   side_cur;
        logic [NUM_W-1:0]            dsh;
        logic [LANES-1:0][NUM_W-1:0] rem_nx;
        logic [LANES-1:0][QUO_W-1:0] quo_nx;

        if (k == 0) begin : g_first
            assign rem_in   = num_in;
            assign quo_in   = '0;
            assign den_cur  = den_in;
            assign side_cur = side_in;
        end else begin : g_next
            assign rem_in   = rem_reg[k-1];
            assign quo_in   = quo_reg[k-1];
            assign den_cur  = den_reg[k-1];
            assign side_cur = side_reg[k-1];
        end

        assign dsh = NUM_W'(den_cur) << B;

        always_comb begin
            for (int i = 0; i < LANES; i++) begin
                quo_nx[i] = quo_in[i];
                if (rem_in[i] >= dsh) begin
                    rem_nx[i]    = rem_in[i] - dsh;
                    quo_nx[i][B] = 1'b1;
                end else begin
                    rem_nx[i]    = rem_in[i];
                    quo_nx[i][B] = 1'b0;
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en[k]) begin
                quo_reg[k]  <= quo_nx;
                side_reg[k] <= side_cur;
            end
        end

        if (k < QUO_W - 1) begin : g_carry
            always_ff @(posedge aclk) begin
                if (en[k]) begin
                    rem_reg[k] <= rem_nx;
                    den_reg[k] <= den_cur;
                end
            end
        end
    end

    assign quo_out  = quo_reg[QUO_W-1];
    assign side_out = side_reg[QUO_W-1];

endmodule

// File: rtl/core/mecanum_wheel_mixer.sv
// ============================================================================
// mecanum_wheel_mixer - four-wheel mecanum inverse kinematics
// Clamps, mixes, normalizes and scales velocity commands into motor commands.
// ============================================================================
// One beat per clock while the output is not stalled. The pipeline has 19
// register stages; eleven of them are the one-bit-per-stage divider that
// normalizes wheel speeds whose magnitude exceeds two; unscaled items pass
// through the same stages. A stalled output holds only the stages behind it
// that are full; empty stages keep taking beats. Configuration (index 0
// neutral command, 1 full scale, 2 reverse offset) is written on cfg_valid,
// takes effect at once and must only change while no beat is in flight.
module mecanum_wheel_mixer import mwm_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [CMD_W-1:0]   s_forward_speed,
    input  logic signed [CMD_W-1:0]   s_side_speed,
    input  logic signed [CMD_W-1:0]   s_turn_speed,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [OUT_W-1:0]          m_wheel_one,
    output logic [OUT_W-1:0]          m_wheel_two,
    output logic [OUT_W-1:0]          m_wheel_three,
    output logic [OUT_W-1:0]          m_wheel_four,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data
);

    logic [NEU_W-1:0] neutral_reg;
    logic [FS_W-1:0]  fs_reg;
    logic [OFS_W-1:0] off_reg;

    logic [NSTG-1:0] valid_reg, valid_next, stage_en;

    logic signed [CMD_W-1:0] cmd_in  [AXES];
    logic signed [CMD_W-1:0] cmd_clp [AXES];
    logic signed [CMD_W-1:0] cmd_reg [AXES];

    logic signed [SPD_W-1:0] spd_nx   [LANES];
    logic signed [SPD_W-1:0] spd1_reg [LANES];
    logic signed [SPD_W-1:0] spd2_reg [LANES];

    logic [SPD_W-1:0] abs_full [LANES];
    logic [AMP_W-1:0] mag [LANES];
    logic [AMP_W-1:0] max01, max23, amp_nx;
    logic [AMP_W-1:0] amp2_reg, amp3_reg, amp4_reg;
    logic             scale2_reg, scale3_reg, scale4_reg;

    logic signed [MOP_W-1:0]  mop3_reg  [LANES];
    logic signed [PROD_W-1:0] prod4_reg [LANES];

    logic signed [PROD_W-1:0]    rnd [LANES];
    logic signed [PROD_W-1:0]    qs  [LANES];
    logic [LANES-1:0][NUM_W-1:0] num_nx, num5_reg;
    logic [DEN_W-1:0]            den5_reg;
    div_side_t                   side_nx, side5_reg;

    logic [LANES-1:0][QUO_W-1:0] div_quo;
    div_side_t                   div_side;

    logic [Q_W-1:0]          qv   [LANES];
    logic signed [R_W-1:0]   r_nx [LANES];
    logic signed [R_W-1:0]   r_reg [LANES];
    logic signed [R_W-1:0]   lo_bound, hi_bound;
    logic signed [R_W-1:0]   c_val [LANES];
    logic [OUT_W-1:0]        wheel_nx  [LANES];
    logic [OUT_W-1:0]        wheel_reg [LANES];

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            neutral_reg <= NEUTRAL_RST;
            fs_reg      <= FS_RST;
            off_reg     <= OFS_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_idx_t'(cfg_index))
                CFG_NEUTRAL:    neutral_reg <= cfg_data[NEU_W-1:0];
                CFG_FULL_SCALE: fs_reg      <= cfg_data[FS_W-1:0];
                CFG_REV_OFFSET: off_reg     <= cfg_data[OFS_W-1:0];
                default: ;
            endcase
        end
    end

    // stage control: advance a stage when it is empty or its successor moves
    always_comb begin
        stage_en[NSTG-1] = !valid_reg[NSTG-1] || m_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            stage_en[k] = !valid_reg[k] || stage_en[k+1];
        end
    end

    always_comb begin
        valid_next[0] = stage_en[0] ? s_valid : valid_reg[0];
        for (int k = 1; k < NSTG; k++) begin
            valid_next[k] = stage_en[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_ready = stage_en[0];

    // clamp
    assign cmd_in[0] = s_forward_speed;
    assign cmd_in[1] = s_side_speed;
    assign cmd_in[2] = s_turn_speed;

    always_comb begin
        for (int j = 0; j < AXES; j++) begin
            if (cmd_in[j] > CLAMP_HI) begin
                cmd_clp[j] = CLAMP_HI;
            end else if (cmd_in[j] < CLAMP_LO) begin
                cmd_clp[j] = CLAMP_LO;
            end else begin
                cmd_clp[j] = cmd_in[j];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[ST_CLAMP]) begin
            cmd_reg <= cmd_clp;
        end
    end

    // mix
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            spd_nx[i] = '0;
            for (int j = 0; j < AXES; j++) begin
                if (MIX_NEG[i][j]) begin
                    spd_nx[i] = spd_nx[i] - SPD_W'(cmd_reg[j]);
                end else begin
                    spd_nx[i] = spd_nx[i] + SPD_W'(cmd_reg[j]);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[ST_MIX]) begin
            spd1_reg <= spd_nx;
        end
    end

    // largest magnitude
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            abs_full[i] = spd1_reg[i][SPD_W-1] ? SPD_W'(-spd1_reg[i]) : SPD_W'(spd1_reg[i]);
            mag[i]      = abs_full[i][AMP_W-1:0];
        end
        max01  = (mag[0] > mag[1]) ? mag[0] : mag[1];
        max23  = (mag[2] > mag[3]) ? mag[2] : mag[3];
        amp_nx = (max01 > max23) ? max01 : max23;
    end

    always_ff @(posedge aclk) begin
        if (stage_en[ST_AMP]) begin
            spd2_reg   <= spd1_reg;
            amp2_reg   <= amp_nx;
            scale2_reg <= 32'(amp_nx) > 32'(LIMIT_INT);
        end
    end

    // multiplier operand: shift scaled speeds to be non-negative
    always_ff @(posedge aclk) begin
        if (stage_en[ST_MOP]) begin
            for (int i = 0; i < LANES; i++) begin
                mop3_reg[i] <= scale2_reg ?
                               MOP_W'(spd2_reg[i]) + $signed({2'b00, amp2_reg}) :
                               MOP_W'(spd2_reg[i]);
            end
            amp3_reg   <= amp2_reg;
            scale3_reg <= scale2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[ST_PROD]) begin
            for (int i = 0; i < LANES; i++) begin
                prod4_reg[i] <= $signed({1'b0, fs_reg}) * mop3_reg[i];
            end
            amp4_reg   <= amp3_reg;
            scale4_reg <= scale3_reg;
        end
    end

    // plain rounding and divider numerator
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            rnd[i]             = prod4_reg[i] + PROD_W'(HALF_INT);
            qs[i]              = rnd[i] >>> FRACTION_BITS;
            side_nx.q_plain[i] = qs[i][Q_W-1:0];
            num_nx[i]          = {prod4_reg[i][NUM_W-3:0], 2'b00} + NUM_W'(amp4_reg);
        end
        side_nx.scale = scale4_reg;
    end

    always_ff @(posedge aclk) begin
        if (stage_en[ST_NUM]) begin
            num5_reg  <= num_nx;
            den5_reg  <= {amp4_reg, 1'b0};
            side5_reg <= side_nx;
        end
    end

    mwm_divider u_div (
        .aclk     (aclk),
        .en       (stage_en[ST_DIV0 +: QUO_W]),
        .num_in   (num5_reg),
        .den_in   (den5_reg),
        .side_in  (side5_reg),
        .quo_out  (div_quo),
        .side_out (div_side)
    );

    // neutral and reverse offset
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            qv[i] = div_side.scale ?
                    Q_W'({1'b0, div_quo[i]}) - Q_W'({fs_reg, 1'b0}) :
                    div_side.q_plain[i];
            r_nx[i] = $signed(R_W'(neutral_reg) + {qv[i][Q_W-1], qv[i]}
                              - (qv[i][Q_W-1] ? R_W'(off_reg) : R_W'(0)));
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[ST_OFS]) begin
            r_reg <= r_nx;
        end
    end

    // clamp to the command window and saturate
    assign lo_bound = $signed(R_W'(neutral_reg) - R_W'({fs_reg, 1'b0}) - R_W'(off_reg));
    assign hi_bound = $signed(R_W'(neutral_reg) + R_W'({fs_reg, 1'b0}));

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            if (r_reg[i] < lo_bound) begin
                c_val[i] = lo_bound;
            end else if (r_reg[i] > hi_bound) begin
                c_val[i] = hi_bound;
            end else begin
                c_val[i] = r_reg[i];
            end
            if (c_val[i] < $signed(R_W'(0))) begin
                wheel_nx[i] = '0;
            end else if (c_val[i] > $signed(R_W'(OUT_MAX))) begin
                wheel_nx[i] = OUT_W'(OUT_MAX);
            end else begin
                wheel_nx[i] = c_val[i][OUT_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[ST_OUT]) begin
            wheel_reg <= wheel_nx;
        end
    end

    assign m_valid       = valid_reg[ST_OUT];
    assign m_wheel_one   = wheel_reg[0];
    assign m_wheel_two   = wheel_reg[1];
    assign m_wheel_three = wheel_reg[2];
    assign m_wheel_four  = wheel_reg[3];

endmodule

// File: rtl/core/mwm_checker.sv
// ============================================================================
// mwm_checker - port-level checks of the mecanum wheel mixer
// Tracks beats in flight and checks result beats, input readiness and stalls.
// ============================================================================
module mwm_checker import mwm_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    input  logic                      s_ready,
    input  logic                      m_valid,
    input  logic                      m_ready,
    input  logic [OUT_W-1:0]          m_wheel_one,
    input  logic [OUT_W-1:0]          m_wheel_two,
    input  logic [OUT_W-1:0]          m_wheel_three,
    input  logic [OUT_W-1:0]          m_wheel_four
);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             in_beat, out_beat;

    assign in_beat  = s_valid && s_ready;
    assign out_beat = m_valid && m_ready;

    always_comb begin
        cnt_next = cnt_reg;
        if (in_beat && !out_beat) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else if (out_beat && !in_beat) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    a_no_phantom_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        out_beat |-> (cnt_reg != '0))
        else $error("result beat without a pending input beat");

    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(NSTG))
        else $error("more beats in flight than pipeline stages");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == '0) |-> s_ready)
        else $error("input stalled with empty pipeline");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_wheel_one)
            && $stable(m_wheel_two) && $stable(m_wheel_three)
            && $stable(m_wheel_four)))
        else $error("stalled result beat changed");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind mecanum_wheel_mixer mwm_checker u_mwm_checker (.*);

// File: sim/tb.sv
`timescale 1ns / 100ps
// ============================================================================
// tb - regression bench for the mecanum wheel mixer
// Drives velocity commands through the valid/ready input channel, predicts
// the four wheel commands of every accepted beat in a scoreboard and checks
// each result beat in order, across several register settings.
// ============================================================================
module tb;
    import mwm_pkg::*;

    localparam int SETTLE_CYCLES  = 24;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        logic [OUT_W-1:0] one;
        logic [OUT_W-1:0] two;
        logic [OUT_W-1:0] three;
        logic [OUT_W-1:0] four;
    } wheel_cmds_t;

    class wheel_scoreboard;
        logic [NEU_W-1:0] neutral;
        logic [FS_W-1:0]  full_scale;
        logic [OFS_W-1:0] rev_offset;
        wheel_cmds_t      pending_cmds[$];
        int               errors;

        function new();
            neutral    = NEUTRAL_RST;
            full_scale = FS_RST;
            rev_offset = OFS_RST;
            errors     = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_NEUTRAL:    neutral    = data[NEU_W-1:0];
                CFG_FULL_SCALE: full_scale = data[FS_W-1:0];
                CFG_REV_OFFSET: rev_offset = data[OFS_W-1:0];
                default: ;
            endcase
        endfunction

        function wheel_cmds_t mix_wheels(logic signed [CMD_W-1:0] fwd,
                                         logic signed [CMD_W-1:0] side,
                                         logic signed [CMD_W-1:0] turn);
            int    signs[LANES][AXES];
            longint unit, limit, amp, num, den, n2, d2, q, r, neu, fs, ofs;
            longint cmd[AXES];
            longint speed[LANES];
            longint wheel[LANES];
            wheel_cmds_t res;
            signs = '{'{1, -1, -1}, '{1, 1, -1}, '{1, 1, 1}, '{1, -1, 1}};
            unit  = longint'(1) <<< FRACTION_BITS;
            limit = 2 * unit;
            neu   = longint'(neutral);
            fs    = longint'(full_scale);
            ofs   = longint'(rev_offset);
            cmd[0] = longint'(fwd);
            cmd[1] = longint'(side);
            cmd[2] = longint'(turn);
            for (int j = 0; j < AXES; j++) begin
                if (cmd[j] > unit) cmd[j] = unit;
                if (cmd[j] < -unit) cmd[j] = -unit;
            end
            amp = 0;
            for (int i = 0; i < LANES; i++) begin
                speed[i] = 0;
                for (int j = 0; j < AXES; j++) speed[i] += signs[i][j] * cmd[j];
                if (speed[i] > amp) amp = speed[i];
                if (-speed[i] > amp) amp = -speed[i];
            end
            for (int i = 0; i < LANES; i++) begin
                if (amp > limit) begin
                    num = fs * speed[i] * 2;
                    den = amp;
                end else begin
                    num = fs * speed[i];
                    den = unit;
                end
                // round half up as floor((2n + d) / 2d)
                n2 = 2 * num + den;
                d2 = 2 * den;
                q  = n2 / d2;
                if ((n2 % d2) != 0 && n2 < 0) q -= 1;
                r = neu + q;
                if (r < neu) r -= ofs;
                if (r < neu - 2 * fs - ofs) r = neu - 2 * fs - ofs;
                if (r > neu + 2 * fs) r = neu + 2 * fs;
                if (r < 0) r = 0;
                if (r > OUT_MAX) r = OUT_MAX;
                wheel[i] = r;
            end
            res.one   = OUT_W'(wheel[0]);
            res.two   = OUT_W'(wheel[1]);
            res.three = OUT_W'(wheel[2]);
            res.four  = OUT_W'(wheel[3]);
            return res;
        endfunction

        function void note_cmd(logic signed [CMD_W-1:0] fwd,
                               logic signed [CMD_W-1:0] side,
                               logic signed [CMD_W-1:0] turn);
            pending_cmds.push_back(mix_wheels(fwd, side, turn));
        endfunction

        function void compare_field(string name, logic [OUT_W-1:0] exp_val,
                                    logic [OUT_W-1:0] act_val);
            if (exp_val !== act_val) begin
                $error("%s: expected %0d, got %0d", name, exp_val, act_val);
                errors++;
            end
        endfunction

        function void check_result(logic [OUT_W-1:0] w1, logic [OUT_W-1:0] w2,
                                   logic [OUT_W-1:0] w3, logic [OUT_W-1:0] w4);
            wheel_cmds_t exp_cmds;
            if (pending_cmds.size() == 0) begin
                $error("unexpected result beat: %0d %0d %0d %0d", w1, w2, w3, w4);
                errors++;
                return;
            end
            exp_cmds = pending_cmds.pop_front();
            compare_field("wheel_one", exp_cmds.one, w1);
            compare_field("wheel_two", exp_cmds.two, w2);
            compare_field("wheel_three", exp_cmds.three, w3);
            compare_field("wheel_four", exp_cmds.four, w4);
        endfunction
    endclass

    logic                     aclk = 1'b0;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    logic signed [CMD_W-1:0]  s_forward_speed;
    logic signed [CMD_W-1:0]  s_side_speed;
    logic signed [CMD_W-1:0]  s_turn_speed;
    logic                     m_valid;
    logic                     m_ready;
    logic [OUT_W-1:0]         m_wheel_one;
    logic [OUT_W-1:0]         m_wheel_two;
    logic [OUT_W-1:0]         m_wheel_three;
    logic [OUT_W-1:0]         m_wheel_four;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [CFG_DATA_W-1:0]    cfg_data;

    wheel_scoreboard sb = new();
    int idle_odds  = 4;
    int stall_odds = 4;
    int idle_cycles = 0;

    mecanum_wheel_mixer u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_forward_speed (s_forward_speed),
        .s_side_speed    (s_side_speed),
        .s_turn_speed    (s_turn_speed),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_wheel_one     (m_wheel_one),
        .m_wheel_two     (m_wheel_two),
        .m_wheel_three   (m_wheel_three),
        .m_wheel_four    (m_wheel_four),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always #4 aclk = ~aclk;

    // output backpressure: random stall bursts
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_wheel_one, m_wheel_two, m_wheel_three, m_wheel_four);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("mecanum_wheel_mixer regression: fail");
            $finish;
        end
    end

    task automatic send_cmd(input logic signed [CMD_W-1:0] fwd,
                            input logic signed [CMD_W-1:0] side,
                            input logic signed [CMD_W-1:0] turn);
        @(negedge aclk);
        if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge aclk);
        end
        s_valid         <= 1'b1;
        s_forward_speed <= fwd;
        s_side_speed    <= side;
        s_turn_speed    <= turn;
        do @(posedge aclk); while (!s_ready);
        sb.note_cmd(fwd, side, turn);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, data);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic program_regs(input logic [CFG_DATA_W-1:0] neu,
                                input logic [CFG_DATA_W-1:0] fs,
                                input logic [CFG_DATA_W-1:0] ofs);
        write_reg(CFG_NEUTRAL, neu);
        write_reg(CFG_FULL_SCALE, fs);
        write_reg(CFG_REV_OFFSET, ofs);
    endtask

    // drop valid and wait until every beat in flight has come out
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pending_cmds.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic signed [CMD_W-1:0] rand_cmd();
        logic signed [CMD_W-1:0] corner_vals[9];
        int v;
        corner_vals = '{-16'sd32768, -16'sd16385, -16'sd16384, -16'sd1, 16'sd0,
                        16'sd1, 16'sd16384, 16'sd16385, 16'sd32767};
        case ($urandom_range(0, 9))
            0, 1:    v = int'($urandom);
            2, 3:    v = int'(corner_vals[$urandom_range(0, 8)]);
            4:       v = int'($urandom_range(0, 400)) - 200;
            default: v = int'($urandom_range(0, 32768)) - 16384;
        endcase
        return CMD_W'(v);
    endfunction

    task automatic run_random(input int count);
        repeat (count) send_cmd(rand_cmd(), rand_cmd(), rand_cmd());
    endtask

    initial begin
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_forward_speed = '0;
        s_side_speed    = '0;
        s_turn_speed    = '0;
        cfg_valid       = 1'b0;
        cfg_index       = CFG_NEUTRAL;
        cfg_data        = '0;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        // reset register values
        send_cmd(16'sd0, 16'sd0, 16'sd0);
        send_cmd(16'sd16384, 16'sd0, 16'sd0);
        send_cmd(-16'sd16384, 16'sd0, 16'sd0);
        send_cmd(16'sd0, 16'sd16384, 16'sd0);
        send_cmd(16'sd0, 16'sd0, -16'sd16384);
        send_cmd(16'sd32767, 16'sd32767, 16'sd32767);
        send_cmd(-16'sd32768, -16'sd32768, -16'sd32768);
        send_cmd(16'sd16385, -16'sd16385, 16'sd0);
        send_cmd(16'sd16384, 16'sd16384, 16'sd16384);
        send_cmd(16'sd16384, -16'sd16384, 16'sd16384);
        send_cmd(16'sd16384, 16'sd16384, 16'sd0);
        send_cmd(16'sd16384, 16'sd16384, 16'sd1);
        send_cmd(16'sd8192, 16'sd8192, 16'sd0);
        send_cmd(-16'sd1, 16'sd0, 16'sd0);
        send_cmd(-16'sd100, 16'sd0, 16'sd0);
        send_cmd(16'sd100, -16'sd7, 16'sd3);
        run_random(250);
        drain();

        // negative lower bound, saturate at zero
        idle_odds  = 3;
        stall_odds = 3;
        program_regs(11'd0, 11'd511, 11'd63);
        run_random(250);
        drain();

        // upper bound beyond output range
        idle_odds  = 0;
        stall_odds = 0;
        program_regs(11'd2047, 11'd511, 11'd0);
        run_random(250);
        drain();

        // half-step rounding, upper bits of narrow registers dropped
        idle_odds  = 5;
        stall_odds = 2;
        program_regs(11'd1024, 11'h780, 11'h7C1);
        write_reg(CFG_SPARE, 11'h555);
        send_cmd(16'sd64, 16'sd0, 16'sd0);
        send_cmd(-16'sd64, 16'sd0, 16'sd0);
        send_cmd(16'sd192, 16'sd0, 16'sd0);
        send_cmd(-16'sd192, 16'sd0, 16'sd0);
        send_cmd(16'sd16384, 16'sd16384, 16'sd16384);
        run_random(250);
        drain();

        // zero full scale
        idle_odds  = 2;
        stall_odds = 5;
        program_regs(11'd0, 11'h600, 11'h7FF);
        run_random(150);
        drain();

        idle_odds  = 4;
        stall_odds = 4;
        program_regs(11'($urandom), 11'($urandom), 11'($urandom));
        run_random(250);
        drain();

        idle_odds  = 0;
        stall_odds = 0;
        program_regs(11'($urandom), 11'($urandom), 11'($urandom));
        run_random(250);
        drain();

        if (sb.errors == 0 && sb.pending_cmds.size() == 0) begin
            $display("mecanum_wheel_mixer regression: pass");
        end else begin
            $display("mecanum_wheel_mixer regression: fail");
        end
        $finish;
    end

endmodule
